/* rtl/drmt_pkg.sv */
// Shared types, sizes and rectangle arithmetic for the dirty rectangle table.
// No dependencies; dirty_rect_merge_table.sv and the bench import this package.
`default_nettype none

package drmt_pkg;

   localparam int MAX_RECTS = 16;
   localparam int CNT_W     = $clog2(MAX_RECTS + 1);
   localparam int ADDR_W    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int IDX_W     = 4;
   localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   localparam logic ST_OK    = 1'b0;
   localparam logic ST_RANGE = 1'b1;

   localparam logic signed [15:0] SIZE_SAT = 16'sd32767;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] w;
      logic signed [15:0] h;
   } rect_type;

   localparam int RECT_W = $bits(rect_type);

   // Closed-interval overlap or contact on both axes.
   function automatic logic rects_touch(rect_type a, rect_type b);
      logic signed [16:0] ar, br, ab, bb;
      ar = $signed({a.x[15], a.x}) + $signed({a.w[15], a.w});
      br = $signed({b.x[15], b.x}) + $signed({b.w[15], b.w});
      ab = $signed({a.y[15], a.y}) + $signed({a.h[15], a.h});
      bb = $signed({b.y[15], b.y}) + $signed({b.h[15], b.h});
      return ($signed({a.x[15], a.x}) <= br) && ($signed({b.x[15], b.x}) <= ar) &&
             ($signed({a.y[15], a.y}) <= bb) && ($signed({b.y[15], b.y}) <= ab);
   endfunction

   // Bounding box of two rectangles, width and height clamped to 32767.
   function automatic rect_type rect_union(rect_type a, rect_type b);
      logic signed [16:0] ar, br, ab, bb, rt, bt;
      logic signed [15:0] lx, ty;
      logic signed [17:0] uw, uh;
      rect_type r;
      ar = $signed({a.x[15], a.x}) + $signed({a.w[15], a.w});
      br = $signed({b.x[15], b.x}) + $signed({b.w[15], b.w});
      ab = $signed({a.y[15], a.y}) + $signed({a.h[15], a.h});
      bb = $signed({b.y[15], b.y}) + $signed({b.h[15], b.h});
      rt = (ar > br) ? ar : br;
      bt = (ab > bb) ? ab : bb;
      lx = (a.x < b.x) ? a.x : b.x;
      ty = (a.y < b.y) ? a.y : b.y;
      uw = $signed({rt[16], rt}) - $signed({lx[15], lx[15], lx});
      uh = $signed({bt[16], bt}) - $signed({ty[15], ty[15], ty});
      r.x = lx;
      r.y = ty;
      r.w = (uw > $signed({2'b00, SIZE_SAT})) ? SIZE_SAT : uw[15:0];
      r.h = (uh > $signed({2'b00, SIZE_SAT})) ? SIZE_SAT : uh[15:0];
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/drmt_if.sv */
// Valid/ready channel interfaces for the request and response sides.
// No dependencies beyond plain logic types.
`default_nettype none

interface drmt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [15:0] rect_x;
   logic signed [15:0] rect_y;
   logic signed [15:0] rect_w;
   logic signed [15:0] rect_h;
   logic [3:0]         entry_index;

   modport source(output valid, operation, rect_x, rect_y, rect_w, rect_h, entry_index,
                  input ready);
   modport sink(input valid, operation, rect_x, rect_y, rect_w, rect_h, entry_index,
                output ready);
endinterface

interface drmt_rsp_if;
   logic               valid;
   logic               ready;
   logic               status;
   logic [4:0]         entry_count;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic signed [15:0] out_w;
   logic signed [15:0] out_h;

   modport source(output valid, status, entry_count, out_x, out_y, out_w, out_h,
                  input ready);
   modport sink(input valid, status, entry_count, out_x, out_y, out_w, out_h,
                output ready);
endinterface

`default_nettype wire

/* rtl/drmt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module drmt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [AW-1:0]          wr_addr,
   input  wire logic [WIDTH-1:0]       wr_data,
   input  wire logic [AW-1:0]          rd_addr,
   output logic      [WIDTH-1:0]       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

`default_nettype wire

/* rtl/dirty_rect_merge_table.sv */
// Dirty rectangle table: merge-on-add sequencer around one rectangle RAM.
// Depends on drmt_pkg, drmt_req_if / drmt_rsp_if and drmt_ram.
//
//   channel   dir   handshake          payload
//   req_ch    in    valid / ready      operation, rect_x/y/w/h, entry_index
//   rsp_ch    out   valid / ready      status, entry_count, out_x/y/w/h
//
// One item at a time. Clear, an empty add, the unused code and a read past the
// count go from accept to result; a read within the count waits for RAM data.
// An add scans and checks each entry visited in each merge pass, merges and moves
// per merge and ends each pass; a full table then reads and folds in every entry.
// The single RAM read port reads one entry per visit.
// Synchronous reset empties the table; RAM contents need no clearing.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module dirty_rect_merge_table import drmt_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   drmt_req_if.sink   req_ch,
   drmt_rsp_if.source rsp_ch
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_CHECK,
      S_MERGE,
      S_MOVE,
      S_FREAD,
      S_FACC,
      S_FORIG,
      S_RDWAIT,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               merged_ff, merged_in;
   rect_type           acc_ff, acc_in;
   rect_type           orig_ff, orig_in;
   rect_type           ent_ff, ent_in;
   logic               res_status_ff, res_status_in;
   rect_type           res_rect_ff, res_rect_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [4:0]         rsp_count_ff, rsp_count_in;
   rect_type           rsp_rect_ff, rsp_rect_in;

   // RAM port
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [RECT_W-1:0]  ram_wdata;
   logic [RECT_W-1:0]  ram_rdata;
   rect_type           rd_rect;

   logic               req_take;
   logic [CNT_W-1:0]   count_m1;
   logic [CNT_W-1:0]   scan_p1;
   rect_type           req_rect;

   drmt_ram #(
      .WIDTH(RECT_W),
      .DEPTH(MAX_RECTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_rect  = rect_type'(ram_rdata);
   assign count_m1 = count_ff - CNT_W'(1);
   assign scan_p1  = scan_ff + CNT_W'(1);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && (state_ff == S_IDLE);

   assign req_rect.x = req_ch.rect_x;
   assign req_rect.y = req_ch.rect_y;
   assign req_rect.w = req_ch.rect_w;
   assign req_rect.h = req_ch.rect_h;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_count = rsp_count_ff;
   assign rsp_ch.out_x       = rsp_rect_ff.x;
   assign rsp_ch.out_y       = rsp_rect_ff.y;
   assign rsp_ch.out_w       = rsp_rect_ff.w;
   assign rsp_ch.out_h       = rsp_rect_ff.h;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      merged_in     = merged_ff;
      acc_in        = acc_ff;
      orig_in       = orig_ff;
      ent_in        = ent_ff;
      res_status_in = res_status_ff;
      res_rect_in   = res_rect_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_rect_in   = rsp_rect_ff;
      ram_we        = 1'b0;
      ram_waddr     = scan_ff[ADDR_W-1:0];
      ram_wdata     = RECT_W'(acc_ff);
      ram_raddr     = scan_ff[ADDR_W-1:0];

      // drop the held result once the sink takes it
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               res_status_in = ST_OK;
               res_rect_in   = '0;
               case (op_type'(req_ch.operation))
                  OP_ADD: begin
                     // empty rectangles leave the table alone
                     if (req_ch.rect_w > 16'sd0 && req_ch.rect_h > 16'sd0) begin
                        acc_in    = req_rect;
                        orig_in   = req_rect;
                        scan_in   = '0;
                        merged_in = 1'b0;
                        state_in  = S_SCAN;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  OP_READ: begin
                     if (CMP_W'(req_ch.entry_index) < CMP_W'(count_ff)) begin
                        ram_raddr = ADDR_W'(req_ch.entry_index);
                        state_in  = S_RDWAIT;
                     end else begin
                        res_status_in = ST_RANGE;
                        state_in      = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (scan_ff < count_ff) begin
               ram_raddr = scan_ff[ADDR_W-1:0];
               state_in  = S_CHECK;
            end else if (merged_ff) begin
               // another pass over the shrunken table
               merged_in = 1'b0;
               scan_in   = '0;
            end else if (count_ff < CNT_W'(MAX_RECTS)) begin
               ram_we    = 1'b1;
               ram_waddr = count_ff[ADDR_W-1:0];
               ram_wdata = RECT_W'(acc_ff);
               count_in  = count_ff + CNT_W'(1);
               state_in  = S_DONE;
            end else begin
               // no room: fold the whole table into entry 0
               scan_in  = '0;
               state_in = S_FREAD;
            end
         end

         S_CHECK: begin
            if (rects_touch(acc_ff, rd_rect)) begin
               ent_in   = rd_rect;
               state_in = S_MERGE;
            end else begin
               scan_in  = scan_p1;
               state_in = S_SCAN;
            end
         end

         S_MERGE: begin
            acc_in    = rect_union(acc_ff, ent_ff);
            merged_in = 1'b1;
            ram_raddr = count_m1[ADDR_W-1:0];
            state_in  = S_MOVE;
         end

         S_MOVE: begin
            // last entry fills the merged slot; it is skipped this pass
            ram_we    = 1'b1;
            ram_waddr = scan_ff[ADDR_W-1:0];
            ram_wdata = ram_rdata;
            count_in  = count_m1;
            scan_in   = scan_p1;
            state_in  = S_SCAN;
         end

         S_FREAD: begin
            ram_raddr = scan_ff[ADDR_W-1:0];
            state_in  = S_FACC;
         end

         S_FACC: begin
            acc_in  = (scan_ff == '0) ? rd_rect : rect_union(acc_ff, rd_rect);
            scan_in = scan_p1;
            if (scan_p1 < count_ff) begin
               state_in = S_FREAD;
            end else begin
               state_in = S_FORIG;
            end
         end

         S_FORIG: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = RECT_W'(rect_union(acc_ff, orig_ff));
            count_in  = CNT_W'(1);
            state_in  = S_DONE;
         end

         S_RDWAIT: begin
            res_rect_in = rd_rect;
            state_in    = S_DONE;
         end

         S_DONE: begin
            // load the output register when it is empty or being emptied
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = 5'(count_ff);
               rsp_rect_in   = res_rect_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         merged_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         merged_ff    <= merged_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff        <= acc_in;
      orig_ff       <= orig_in;
      ent_ff        <= ent_in;
      res_status_ff <= res_status_in;
      res_rect_ff   <= res_rect_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_rect_ff   <= rsp_rect_in;
   end

`ifndef SYNTHESIS
   // A clear item empties the table on the following cycle.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_ch.operation == OP_CLEAR) |=> (count_ff == '0))
      else $error("table not empty after clear");

   // A merge step only runs while the table holds entries.
   a_merge_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |-> (count_ff != '0))
      else $error("merge with empty table");

   // A range error never carries rectangle data.
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_RANGE) |-> (rsp_rect_ff == '0))
      else $error("range error with nonzero payload");

   // Reported count never exceeds the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff <= 5'(MAX_RECTS)))
      else $error("reported count above table size");
`endif

endmodule

`default_nettype wire

/* tb/dirty_rect_merge_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for dirty_rect_merge_table: directed table, then random traffic.
// Depends on drmt_pkg, drmt_req_if / drmt_rsp_if and the block itself.

module dirty_rect_merge_table_tb;
   import drmt_pkg::*;

   localparam int STALL_LIMIT  = 5000;  // cycles with no handshake on either side
   localparam int RANDOM_ITEMS = 750;
   localparam int QUIET_TAIL   = 120;   // last random items run without idling
   localparam int DRAIN_CYCLES = 64;

   typedef struct {
      op_type             op;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] w;
      logic signed [15:0] h;
      logic [3:0]         idx;
   } table_req;

   typedef struct {
      logic               status;
      logic [4:0]         count;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] w;
      logic signed [15:0] h;
   } table_reply;

   // One row of the directed table; typed rows carry their reply, the rest use the mirror.
   typedef struct {
      table_req   req;
      bit         typed;
      table_reply reply;
   } plan_row;

   logic clock = 1'b0;
   logic reset;

   drmt_req_if req_ch ();
   drmt_rsp_if rsp_ch ();

   dirty_rect_merge_table dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mirror of the rectangle table, kept in step with every accepted item.
   rect_type   mirror_rects [MAX_RECTS];
   int         mirror_count;
   table_reply replies_due [$];
   int         error_count = 0;
   bit         gaps_on;

   // Closed intervals: shared edges and corners count as contact. Work at 32 bits.
   function automatic bit rects_meet(rect_type a, rect_type b);
      return (int'(a.x) <= int'(b.x) + int'(b.w)) && (int'(b.x) <= int'(a.x) + int'(a.w)) &&
             (int'(a.y) <= int'(b.y) + int'(b.h)) && (int'(b.y) <= int'(a.y) + int'(a.h));
   endfunction

   // Bounding box; clamp width and height at 32767.
   function automatic rect_type rect_hull(rect_type a, rect_type b);
      int ra, rb, ba, bb, lx, ty, wd, ht;
      rect_type r;
      ra = int'(a.x) + int'(a.w);
      rb = int'(b.x) + int'(b.w);
      ba = int'(a.y) + int'(a.h);
      bb = int'(b.y) + int'(b.h);
      lx = (int'(a.x) < int'(b.x)) ? int'(a.x) : int'(b.x);
      ty = (int'(a.y) < int'(b.y)) ? int'(a.y) : int'(b.y);
      wd = ((ra > rb) ? ra : rb) - lx;
      ht = ((ba > bb) ? ba : bb) - ty;
      if (wd > 32767) wd = 32767;
      if (ht > 32767) ht = 32767;
      r.x = lx[15:0];
      r.y = ty[15:0];
      r.w = wd[15:0];
      r.h = ht[15:0];
      return r;
   endfunction

   // Merge passes, then append or collapse the whole table when it is full.
   function automatic void table_add(rect_type orig);
      rect_type acc;
      bit       hit;
      int       i;
      acc = orig;
      do begin
         hit = 1'b0;
         // the entry moved into slot i is skipped until the next pass
         for (i = 0; i < mirror_count; i++) begin
            if (rects_meet(acc, mirror_rects[i])) begin
               acc = rect_hull(acc, mirror_rects[i]);
               mirror_rects[i] = mirror_rects[mirror_count - 1];
               mirror_count--;
               hit = 1'b1;
            end
         end
      end while (hit);
      if (mirror_count < MAX_RECTS) begin
         mirror_rects[mirror_count] = acc;
         mirror_count++;
      end else begin
         acc = mirror_rects[0];
         for (i = 1; i < mirror_count; i++) acc = rect_hull(acc, mirror_rects[i]);
         mirror_rects[0] = rect_hull(acc, orig);
         mirror_count = 1;
      end
   endfunction

   function automatic table_reply mk_reply(logic status, int count);
      table_reply r;
      r.status = status;
      r.count  = count[4:0];
      r.x = '0;
      r.y = '0;
      r.w = '0;
      r.h = '0;
      return r;
   endfunction

   // Advance the mirror by one item and return the reply it owes.
   function automatic table_reply predict_reply(table_req q);
      table_reply p;
      rect_type   nb;
      p = mk_reply(ST_OK, 0);
      case (q.op)
         OP_ADD: begin
            if (q.w > 0 && q.h > 0) begin
               nb.x = q.x;
               nb.y = q.y;
               nb.w = q.w;
               nb.h = q.h;
               table_add(nb);
            end
         end
         OP_CLEAR: mirror_count = 0;
         OP_READ: begin
            if (int'(q.idx) < mirror_count) begin
               p.x = mirror_rects[q.idx].x;
               p.y = mirror_rects[q.idx].y;
               p.w = mirror_rects[q.idx].w;
               p.h = mirror_rects[q.idx].h;
            end else begin
               p.status = ST_RANGE;
            end
         end
         default: ;
      endcase
      p.count = mirror_count[4:0];
      return p;
   endfunction

   function automatic table_req mk_req(op_type op, int x, int y, int w, int h, int idx);
      table_req q;
      q.op  = op;
      q.x   = x[15:0];
      q.y   = y[15:0];
      q.w   = w[15:0];
      q.h   = h[15:0];
      q.idx = idx[3:0];
      return q;
   endfunction

   function automatic plan_row mk_row(table_req q, bit typed, table_reply r);
      plan_row row;
      row.req   = q;
      row.typed = typed;
      row.reply = r;
      return row;
   endfunction

   // Mostly clustered adds so the table fills, merges and collapses; the rest is
   // full-range noise, empty adds, reads, clears and the unused opcode.
   function automatic table_req random_req();
      table_req q;
      int       pick, span, center, ext, v;
      q.op  = OP_ADD;
      q.x   = 16'($urandom);
      q.y   = 16'($urandom);
      q.w   = 16'($urandom);
      q.h   = 16'($urandom);
      q.idx = 4'($urandom_range(0, 15));
      pick  = $urandom_range(0, 99);
      if (pick < 62) begin
         case ($urandom_range(0, 2))
            0:       span = 64;
            1:       span = 1024;
            default: span = 8192;
         endcase
         case ($urandom_range(0, 3))
            0:       center = 0;
            1:       center = 32700;
            2:       center = -32700;
            default: center = int'($urandom_range(0, 65535)) - 32768;
         endcase
         ext = span / 8;
         v = center + int'($urandom_range(0, span)) - span / 2;
         q.x = v[15:0];
         v = center + int'($urandom_range(0, span)) - span / 2;
         q.y = v[15:0];
         v = ($urandom_range(0, 19) == 0) ? int'($urandom_range(1, 32767))
                                          : int'($urandom_range(1, ext));
         q.w = v[15:0];
         v = ($urandom_range(0, 19) == 0) ? int'($urandom_range(1, 32767))
                                          : int'($urandom_range(1, ext));
         q.h = v[15:0];
      end else if (pick < 67) begin
         // empty add: force one side to zero or below
         v = -int'($urandom_range(0, 32768));
         if ($urandom_range(0, 1) == 1) q.w = v[15:0];
         else q.h = v[15:0];
      end else if (pick < 72) begin
         ;  // keep full-range fields as drawn
      end else if (pick < 93) begin
         q.op = OP_READ;
      end else if (pick < 97) begin
         q.op = OP_CLEAR;
      end else begin
         q.op = OP_NOP;
      end
      return q;
   endfunction

   // Present one item, hold it until taken, then record the reply it owes.
   task automatic send_item(table_req q, bit typed, table_reply typed_reply);
      table_reply p;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= q.op;
      req_ch.rect_x      <= q.x;
      req_ch.rect_y      <= q.y;
      req_ch.rect_w      <= q.w;
      req_ch.rect_h      <= q.h;
      req_ch.entry_index <= q.idx;
      do @(posedge clock); while (!req_ch.ready);
      p = predict_reply(q);
      replies_due.push_back(typed ? typed_reply : p);
   endtask

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Compare every reply taken against the oldest one owed.
   always @(posedge clock) begin
      table_reply want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (replies_due.size() == 0) begin
            $error("reply with none owed: status %0d count %0d", rsp_ch.status,
                   rsp_ch.entry_count);
            error_count++;
         end else begin
            want = replies_due.pop_front();
            check_field("status", int'(want.status), int'(rsp_ch.status));
            check_field("entry_count", int'(want.count), int'(rsp_ch.entry_count));
            check_field("out_x", int'(want.x), int'(rsp_ch.out_x));
            check_field("out_y", int'(want.y), int'(rsp_ch.out_y));
            check_field("out_w", int'(want.w), int'(rsp_ch.out_w));
            check_field("out_h", int'(want.h), int'(rsp_ch.out_h));
         end
      end
   end

   // Drop ready in random bursts while idling is on.
   initial begin : reply_stalls
      forever begin
         @(posedge clock);
         if (gaps_on && !reset && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // End the run with an error once the quiet counter, cleared by reset or any handshake, reaches STALL_LIMIT.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      plan_row    plan [$];
      table_reply nil;
      int         k;

      req_ch.valid       <= 1'b0;
      req_ch.operation   <= OP_NOP;
      req_ch.rect_x      <= '0;
      req_ch.rect_y      <= '0;
      req_ch.rect_w      <= '0;
      req_ch.rect_h      <= '0;
      req_ch.entry_index <= '0;
      rsp_ch.ready       <= 1'b1;
      reset              <= 1'b1;
      gaps_on      = 1'b1;
      mirror_count = 0;
      nil = mk_reply(ST_OK, 0);

      // Directed table. Range error on an empty table at the top index.
      plan.push_back(mk_row(mk_req(OP_READ, 0, 0, 0, 0, 15), 1'b1, mk_reply(ST_RANGE, 0)));
      // Empty adds: zero width, most negative height.
      plan.push_back(mk_row(mk_req(OP_ADD, 100, 100, 0, 5, 0), 1'b1, mk_reply(ST_OK, 0)));
      plan.push_back(mk_row(mk_req(OP_ADD, 100, 100, 5, -32768, 0), 1'b1,
                            mk_reply(ST_OK, 0)));
      // Opposite corners of the coordinate space; they do not meet.
      plan.push_back(mk_row(mk_req(OP_ADD, -32768, -32768, 1, 1, 0), 1'b1,
                            mk_reply(ST_OK, 1)));
      plan.push_back(mk_row(mk_req(OP_ADD, 32767, 32767, 32767, 32767, 0), 1'b1,
                            mk_reply(ST_OK, 2)));
      // Corner contact with the far box; the union width and height saturate.
      plan.push_back(mk_row(mk_req(OP_ADD, 0, 0, 32767, 32767, 0), 1'b0, nil));
      plan.push_back(mk_row(mk_req(OP_READ, 0, 0, 0, 0, 1), 1'b0, nil));
      plan.push_back(mk_row(mk_req(OP_NOP, -1, -1, -1, -1, 7), 1'b0, nil));
      plan.push_back(mk_row(mk_req(OP_CLEAR, 0, 0, 0, 0, 0), 1'b1, mk_reply(ST_OK, 0)));
      // Fill the table with disjoint boxes, then one more to force the collapse.
      for (k = 0; k < MAX_RECTS; k++)
         plan.push_back(mk_row(mk_req(OP_ADD, 4 * k, 0, 1, 1, 0), 1'b1,
                               mk_reply(ST_OK, k + 1)));
      plan.push_back(mk_row(mk_req(OP_ADD, 100, 0, 1, 1, 0), 1'b1, mk_reply(ST_OK, 1)));
      plan.push_back(mk_row(mk_req(OP_READ, 0, 0, 0, 0, 0), 1'b0, nil));
      // Touch the collapsed box exactly at its bottom-right corner.
      plan.push_back(mk_row(mk_req(OP_ADD, 101, 1, 5, 5, 0), 1'b0, nil));
      plan.push_back(mk_row(mk_req(OP_READ, 0, 0, 0, 0, 1), 1'b0, nil));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_item(plan[i].req, plan[i].typed, plan[i].reply);

      // Random part: idle in some blocks of items, none in the tail.
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         gaps_on = (k < RANDOM_ITEMS - QUIET_TAIL) && ((k / 50) % 4 != 3);
         send_item(random_req(), 1'b0, nil);
      end
      req_ch.valid <= 1'b0;
      gaps_on = 1'b0;

      // Drain owed replies, then hold a little longer to catch strays.
      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/drmt_pkg.sv
rtl/drmt_if.sv
rtl/drmt_ram.sv
rtl/dirty_rect_merge_table.sv
tb/dirty_rect_merge_table_tb.sv
